// ===== rtl/sip_pkg.sv =====
package sip_pkg;

    localparam int CW     = 32;
    localparam int NIN    = 8;
    localparam int DW     = 33;
    localparam int PW     = 64;
    localparam int PRW    = 66;
    localparam int CABW   = 65;
    localparam int DENW   = 67;
    localparam int DMAGW  = 66;
    localparam int NUMW   = 99;
    localparam int NMAGW  = 98;
    localparam int QBITS  = 41;
    localparam int QW     = 42;
    localparam int TOLW   = 16;
    localparam int RW     = DMAGW;
    localparam int HALF   = 32;

    localparam int AX = 0;
    localparam int AY = 1;
    localparam int BX = 2;
    localparam int BY = 3;
    localparam int CX = 4;
    localparam int CY = 5;
    localparam int DX = 6;
    localparam int DY = 7;

    typedef logic signed [QW-1:0] bound_t;

    localparam logic [QBITS-1:0] Q_CAP = {1'b1, {(QBITS-1){1'b0}}};
    localparam bound_t SAT_HI = {{(QW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam bound_t SAT_LO = {{(QW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    typedef struct packed {
        logic          special;
        logic          den_zero;
        logic          neg_x;
        logic          neg_y;
        logic [CW-1:0] spx;
        logic [CW-1:0] spy;
        bound_t        abx_lo;
        bound_t        abx_hi;
        bound_t        aby_lo;
        bound_t        aby_hi;
        bound_t        cdx_lo;
        bound_t        cdx_hi;
        bound_t        cdy_lo;
        bound_t        cdy_hi;
    } side_t;

endpackage

// ===== rtl/segment_intersection_point_top.sv =====
// Channel   Direction  Handshake         Payload
// s_        in         s_tvalid/tready   s_tdata: ax ay bx by cx cy dx dy (32 b each)
// m_        out        m_tvalid/tready   m_tdata: hit_x hit_y; m_tuser: intersects
// cfg_      in         cfg_wen           cfg_wdata: box_tolerance
// One segment pair per cycle while s_tready is high; results leave through the output register.
// Most of the depth is the 41-step restoring divider, one quotient bit per stage.
// Reset clears valid bits and loads box_tolerance with 0.05 in the fixed-point format.
// The whole pipeline holds when the output skid register is full; s_tready
// drops only then.
module segment_intersection_point_top
    import sip_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wen,
    input  logic [TOLW-1:0]   cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [NIN*CW-1:0] s_tdata,   // ax, ay, bx, by, cx, cy, dx, dy
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [2*CW-1:0]   m_tdata,   // hit_x, hit_y
    output logic              m_tuser    // intersects
);

    localparam int TOL_RAW = ((5 << FRAC_BITS) + 50) / 100;
    localparam int TOL_MAX = (1 << TOLW) - 1;
    localparam logic [TOLW-1:0] TOL_RESET = TOLW'((TOL_RAW > TOL_MAX) ? TOL_MAX : TOL_RAW);
    localparam int OW = 2 * CW + 1;

    logic [TOLW-1:0]  tol_reg;
    logic             en;
    logic             f_v;
    side_t            f_side;
    logic [NMAGW-1:0] nxm, nym;
    logic [DMAGW-1:0] dm;
    logic             ovf_x, ovf_y;
    logic [QBITS-1:0] qx, qy;

    logic             v_dl_reg   [QBITS];
    side_t            side_dl_reg[QBITS];
    logic             ox_dl_reg  [QBITS];
    logic             oy_dl_reg  [QBITS];

    logic             v_f1_reg;
    side_t            side_f1_reg;
    bound_t           px_f1_reg, py_f1_reg;
    logic [QBITS-1:0] qxs, qys;

    logic             v_f2_reg;
    logic [OW-1:0]    res_f2_reg;
    logic [OW-1:0]    res_next;
    logic             box_hit;
    logic [CW-1:0]    ox, oy;
    logic [OW-1:0]    out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_wen)
        begin
            tol_reg <= cfg_wdata;
        end
    end

    sip_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .tol       (tol_reg),
        .out_valid (f_v),
        .out_side  (f_side),
        .nx_mag    (nxm),
        .ny_mag    (nym),
        .den_mag   (dm)
    );

    assign ovf_x = (NMAGW + QBITS)'(nxm) >= ((NMAGW + QBITS)'(dm) << QBITS);
    assign ovf_y = (NMAGW + QBITS)'(nym) >= ((NMAGW + QBITS)'(dm) << QBITS);

    sip_div u_div_x (
        .clk   (clk),
        .en    (en),
        .n_mag (nxm),
        .d_mag (dm),
        .q     (qx)
    );

    sip_div u_div_y (
        .clk   (clk),
        .en    (en),
        .n_mag (nym),
        .d_mag (dm),
        .q     (qy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QBITS; k++)
            begin
                v_dl_reg[k] <= 1'b0;
            end
            v_f1_reg <= 1'b0;
            v_f2_reg <= 1'b0;
        end
        else if (en)
        begin
            v_dl_reg[0] <= f_v;
            for (int k = 1; k < QBITS; k++)
            begin
                v_dl_reg[k] <= v_dl_reg[k-1];
            end
            v_f1_reg <= v_dl_reg[QBITS-1];
            v_f2_reg <= v_f1_reg;
        end
    end

    assign qxs = ox_dl_reg[QBITS-1] ? Q_CAP : qx;
    assign qys = oy_dl_reg[QBITS-1] ? Q_CAP : qy;

    always_comb
    begin
        box_hit = (px_f1_reg >= side_f1_reg.abx_lo) && (px_f1_reg <= side_f1_reg.abx_hi) &&
                  (py_f1_reg >= side_f1_reg.aby_lo) && (py_f1_reg <= side_f1_reg.aby_hi) &&
                  (px_f1_reg >= side_f1_reg.cdx_lo) && (px_f1_reg <= side_f1_reg.cdx_hi) &&
                  (py_f1_reg >= side_f1_reg.cdy_lo) && (py_f1_reg <= side_f1_reg.cdy_hi);
        ox = (px_f1_reg > SAT_HI) ? SAT_HI[CW-1:0] :
             (px_f1_reg < SAT_LO) ? SAT_LO[CW-1:0] : px_f1_reg[CW-1:0];
        oy = (py_f1_reg > SAT_HI) ? SAT_HI[CW-1:0] :
             (py_f1_reg < SAT_LO) ? SAT_LO[CW-1:0] : py_f1_reg[CW-1:0];
        if (side_f1_reg.special)
        begin
            res_next = {1'b1, side_f1_reg.spy, side_f1_reg.spx};
        end
        else if (side_f1_reg.den_zero)
        begin
            res_next = '0;
        end
        else
        begin
            res_next = {box_hit, oy, ox};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_dl_reg[0] <= f_side;
            ox_dl_reg[0]   <= ovf_x;
            oy_dl_reg[0]   <= ovf_y;
            for (int k = 1; k < QBITS; k++)
            begin
                side_dl_reg[k] <= side_dl_reg[k-1];
                ox_dl_reg[k]   <= ox_dl_reg[k-1];
                oy_dl_reg[k]   <= oy_dl_reg[k-1];
            end
            side_f1_reg <= side_dl_reg[QBITS-1];
            px_f1_reg   <= side_dl_reg[QBITS-1].neg_x ? -bound_t'(QW'(qxs)) : bound_t'(QW'(qxs));
            py_f1_reg   <= side_dl_reg[QBITS-1].neg_y ? -bound_t'(QW'(qys)) : bound_t'(QW'(qys));
            res_f2_reg  <= res_next;
        end
    end

    sip_skid #(
        .W (OW)
    ) u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_f2_reg),
        .in_data   (res_f2_reg),
        .advance   (en),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign s_tready = en;
    assign m_tdata  = out_data[2*CW-1:0];
    assign m_tuser  = out_data[2*CW];

    a_full_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        !en |-> m_tvalid)
        else $error("skid holds a result while the output register is empty");

    a_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(en) |-> $past(m_tvalid && !m_tready))
        else $error("skid filled without an output stall");

    a_parallel_miss: assert property (@(posedge clk) disable iff (!rst_n)
        v_f2_reg && en && $past(en && side_f1_reg.den_zero && !side_f1_reg.special)
        |-> res_f2_reg == '0)
        else $error("parallel lines reported a point");

endmodule

// ===== rtl/sip_front.sv =====
module sip_front
    import sip_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [NIN*CW-1:0]     in_data,
    input  logic [TOLW-1:0]       tol,
    output logic                  out_valid,
    output side_t                 out_side,
    output logic [NMAGW-1:0]      nx_mag,
    output logic [NMAGW-1:0]      ny_mag,
    output logic [DMAGW-1:0]      den_mag
);

    logic signed [CW-1:0]   pt1_reg [NIN];
    logic                   v1_reg;

    logic                   v2_reg;
    logic signed [DW-1:0]   rx2_reg, ry2_reg, sx2_reg, sy2_reg;
    logic signed [PW-1:0]   pab1_2_reg, pab2_2_reg, pcd1_2_reg, pcd2_2_reg;
    side_t                  side2_reg;

    logic                   v3_reg;
    logic signed [DW-1:0]   rx3_reg, ry3_reg, sx3_reg, sy3_reg;
    logic signed [PRW-1:0]  prs1_3_reg, prs2_3_reg;
    logic signed [CABW-1:0] cab3_reg, ccd3_reg;
    side_t                  side3_reg;

    logic                   v4_reg;
    logic signed [DENW-1:0] den4_reg;
    logic signed [PRW-1:0]  hsx4_reg, lsx4_reg, hsy4_reg, lsy4_reg;
    logic signed [PRW-1:0]  hrx4_reg, lrx4_reg, hry4_reg, lry4_reg;
    side_t                  side4_reg;

    logic                   v5_reg;
    logic signed [NUMW-1:0] csx5_reg, csy5_reg, rcx5_reg, rcy5_reg;
    logic [DMAGW-1:0]       dmag5_reg;
    logic                   dneg5_reg;
    side_t                  side5_reg;

    logic                   v6_reg;
    logic signed [NUMW-1:0] nx6_reg, ny6_reg;
    logic [DMAGW-1:0]       dmag6_reg;
    logic                   dneg6_reg;
    side_t                  side6_reg;

    logic                   v7_reg;
    logic [NMAGW-1:0]       nxm7_reg, nym7_reg;
    logic [DMAGW-1:0]       dmag7_reg;
    side_t                  side7_reg;

    logic signed [CW-1:0]   pt_in [NIN];
    side_t                  side2_next;
    logic                   sp_a, sp_b;
    logic signed [CW-1:0]   mn_abx, mx_abx, mn_aby, mx_aby, mn_cdx, mx_cdx, mn_cdy, mx_cdy;
    logic signed [DW-1:0]   cab_hi, cab_lo, ccd_hi, ccd_lo;
    logic signed [DENW-1:0] den_abs;
    side_t                  side7_next;

    always_comb
    begin
        for (int k = 0; k < NIN; k++)
        begin
            pt_in[k] = $signed(in_data[k*CW +: CW]);
        end
    end

    always_comb
    begin
        sp_a = (pt1_reg[AX] == pt1_reg[CX] && pt1_reg[AY] == pt1_reg[CY]) ||
               (pt1_reg[AX] == pt1_reg[DX] && pt1_reg[AY] == pt1_reg[DY]);
        sp_b = (pt1_reg[BX] == pt1_reg[CX] && pt1_reg[BY] == pt1_reg[CY]) ||
               (pt1_reg[BX] == pt1_reg[DX] && pt1_reg[BY] == pt1_reg[DY]);
        mn_abx = (pt1_reg[AX] < pt1_reg[BX]) ? pt1_reg[AX] : pt1_reg[BX];
        mx_abx = (pt1_reg[AX] < pt1_reg[BX]) ? pt1_reg[BX] : pt1_reg[AX];
        mn_aby = (pt1_reg[AY] < pt1_reg[BY]) ? pt1_reg[AY] : pt1_reg[BY];
        mx_aby = (pt1_reg[AY] < pt1_reg[BY]) ? pt1_reg[BY] : pt1_reg[AY];
        mn_cdx = (pt1_reg[CX] < pt1_reg[DX]) ? pt1_reg[CX] : pt1_reg[DX];
        mx_cdx = (pt1_reg[CX] < pt1_reg[DX]) ? pt1_reg[DX] : pt1_reg[CX];
        mn_cdy = (pt1_reg[CY] < pt1_reg[DY]) ? pt1_reg[CY] : pt1_reg[DY];
        mx_cdy = (pt1_reg[CY] < pt1_reg[DY]) ? pt1_reg[DY] : pt1_reg[CY];
        side2_next          = '0;
        side2_next.special  = sp_a || sp_b;
        side2_next.spx      = sp_a ? pt1_reg[AX] : pt1_reg[BX];
        side2_next.spy      = sp_a ? pt1_reg[AY] : pt1_reg[BY];
        side2_next.abx_lo   = QW'(mn_abx) - QW'(tol);
        side2_next.abx_hi   = QW'(mx_abx) + QW'(tol);
        side2_next.aby_lo   = QW'(mn_aby) - QW'(tol);
        side2_next.aby_hi   = QW'(mx_aby) + QW'(tol);
        side2_next.cdx_lo   = QW'(mn_cdx) - QW'(tol);
        side2_next.cdx_hi   = QW'(mx_cdx) + QW'(tol);
        side2_next.cdy_lo   = QW'(mn_cdy) - QW'(tol);
        side2_next.cdy_hi   = QW'(mx_cdy) + QW'(tol);
    end

    always_comb
    begin
        cab_hi  = $signed(cab3_reg[CABW-1:HALF]);
        cab_lo  = $signed({1'b0, cab3_reg[HALF-1:0]});
        ccd_hi  = $signed(ccd3_reg[CABW-1:HALF]);
        ccd_lo  = $signed({1'b0, ccd3_reg[HALF-1:0]});
        den_abs = den4_reg[DENW-1] ? -den4_reg : den4_reg;
    end

    always_comb
    begin
        side7_next          = side6_reg;
        side7_next.neg_x    = nx6_reg[NUMW-1] ^ dneg6_reg;
        side7_next.neg_y    = ny6_reg[NUMW-1] ^ dneg6_reg;
        side7_next.den_zero = (dmag6_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt1_reg    <= pt_in;

            rx2_reg    <= DW'(pt1_reg[AX]) - DW'(pt1_reg[BX]);
            ry2_reg    <= DW'(pt1_reg[AY]) - DW'(pt1_reg[BY]);
            sx2_reg    <= DW'(pt1_reg[CX]) - DW'(pt1_reg[DX]);
            sy2_reg    <= DW'(pt1_reg[CY]) - DW'(pt1_reg[DY]);
            pab1_2_reg <= PW'(pt1_reg[AX]) * PW'(pt1_reg[BY]);
            pab2_2_reg <= PW'(pt1_reg[AY]) * PW'(pt1_reg[BX]);
            pcd1_2_reg <= PW'(pt1_reg[CX]) * PW'(pt1_reg[DY]);
            pcd2_2_reg <= PW'(pt1_reg[CY]) * PW'(pt1_reg[DX]);
            side2_reg  <= side2_next;

            rx3_reg    <= rx2_reg;
            ry3_reg    <= ry2_reg;
            sx3_reg    <= sx2_reg;
            sy3_reg    <= sy2_reg;
            prs1_3_reg <= PRW'(rx2_reg) * PRW'(sy2_reg);
            prs2_3_reg <= PRW'(ry2_reg) * PRW'(sx2_reg);
            cab3_reg   <= CABW'(pab1_2_reg) - CABW'(pab2_2_reg);
            ccd3_reg   <= CABW'(pcd1_2_reg) - CABW'(pcd2_2_reg);
            side3_reg  <= side2_reg;

            den4_reg   <= DENW'(prs1_3_reg) - DENW'(prs2_3_reg);
            hsx4_reg   <= PRW'(cab_hi) * PRW'(sx3_reg);
            lsx4_reg   <= PRW'(cab_lo) * PRW'(sx3_reg);
            hsy4_reg   <= PRW'(cab_hi) * PRW'(sy3_reg);
            lsy4_reg   <= PRW'(cab_lo) * PRW'(sy3_reg);
            hrx4_reg   <= PRW'(ccd_hi) * PRW'(rx3_reg);
            lrx4_reg   <= PRW'(ccd_lo) * PRW'(rx3_reg);
            hry4_reg   <= PRW'(ccd_hi) * PRW'(ry3_reg);
            lry4_reg   <= PRW'(ccd_lo) * PRW'(ry3_reg);
            side4_reg  <= side3_reg;

            csx5_reg   <= (NUMW'(hsx4_reg) <<< HALF) + NUMW'(lsx4_reg);
            csy5_reg   <= (NUMW'(hsy4_reg) <<< HALF) + NUMW'(lsy4_reg);
            rcx5_reg   <= (NUMW'(hrx4_reg) <<< HALF) + NUMW'(lrx4_reg);
            rcy5_reg   <= (NUMW'(hry4_reg) <<< HALF) + NUMW'(lry4_reg);
            dmag5_reg  <= den_abs[DMAGW-1:0];
            dneg5_reg  <= den4_reg[DENW-1];
            side5_reg  <= side4_reg;

            nx6_reg    <= csx5_reg - rcx5_reg;
            ny6_reg    <= csy5_reg - rcy5_reg;
            dmag6_reg  <= dmag5_reg;
            dneg6_reg  <= dneg5_reg;
            side6_reg  <= side5_reg;

            nxm7_reg   <= nx6_reg[NUMW-1] ? NMAGW'(-nx6_reg) : NMAGW'(nx6_reg);
            nym7_reg   <= ny6_reg[NUMW-1] ? NMAGW'(-ny6_reg) : NMAGW'(ny6_reg);
            dmag7_reg  <= dmag6_reg;
            side7_reg  <= side7_next;
        end
    end

    assign out_valid = v7_reg;
    assign out_side  = side7_reg;
    assign nx_mag    = nxm7_reg;
    assign ny_mag    = nym7_reg;
    assign den_mag   = dmag7_reg;

endmodule

// ===== rtl/sip_div.sv =====
module sip_div
    import sip_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [NMAGW-1:0] n_mag,
    input  logic [DMAGW-1:0] d_mag,
    output logic [QBITS-1:0] q
);

    logic [RW-1:0]    r_reg   [QBITS];
    logic [QBITS-1:0] nlo_reg [QBITS];
    logic [QBITS-1:0] q_reg   [QBITS];
    logic [DMAGW-1:0] d_reg   [QBITS];

    for (genvar k = 0; k < QBITS; k++)
    begin : g_step
        logic [RW-1:0]    r_in;
        logic [QBITS-1:0] nlo_in;
        logic [QBITS-1:0] q_in;
        logic [DMAGW-1:0] d_in;
        logic [RW:0]      trial;
        logic [RW:0]      diff;
        logic             ge;
        logic [RW-1:0]    r_next;

        if (k == 0)
        begin : g_first
            assign r_in   = RW'(n_mag[NMAGW-1:QBITS]);
            assign nlo_in = n_mag[QBITS-1:0];
            assign q_in   = '0;
            assign d_in   = d_mag;
        end
        else
        begin : g_rest
            assign r_in   = r_reg[k-1];
            assign nlo_in = nlo_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign d_in   = d_reg[k-1];
        end

        assign trial  = {r_in, nlo_in[QBITS-1]};
        assign diff   = trial - {1'b0, d_in};
        assign ge     = (trial >= {1'b0, d_in});
        assign r_next = ge ? diff[RW-1:0] : trial[RW-1:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k]   <= r_next;
                nlo_reg[k] <= {nlo_in[QBITS-2:0], 1'b0};
                q_reg[k]   <= {q_in[QBITS-2:0], ge};
                d_reg[k]   <= d_in;
            end
        end
    end

    assign q = q_reg[QBITS-1];

endmodule

// ===== rtl/sip_skid.sv =====
module sip_skid #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic [W-1:0] in_data,
    output logic         advance,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    logic         out_v_reg;
    logic         sk_v_reg;
    logic [W-1:0] out_d_reg;
    logic [W-1:0] sk_d_reg;
    logic         push;

    assign advance = !sk_v_reg;
    assign push    = in_valid && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
            sk_v_reg  <= 1'b0;
        end
        else if (out_v_reg && !out_ready)
        begin
            if (push)
            begin
                sk_v_reg <= 1'b1;
            end
        end
        else if (sk_v_reg)
        begin
            out_v_reg <= 1'b1;
            sk_v_reg  <= 1'b0;
        end
        else
        begin
            out_v_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_v_reg && !out_ready)
        begin
            if (push)
            begin
                sk_d_reg <= in_data;
            end
        end
        else if (sk_v_reg)
        begin
            out_d_reg <= sk_d_reg;
        end
        else if (push)
        begin
            out_d_reg <= in_data;
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_d_reg;

endmodule

// ===== tb/tb_segment_intersection_point_top.sv =====
module tb_segment_intersection_point_top
    import sip_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam int LATENCY     = 51;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic               hit;
    } point_t;

    typedef struct {
        logic signed [31:0] c [8];
        logic               known;
        point_t             res;
    } vec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wen = 1'b0;
    logic [TOLW-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [NIN*CW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [2*CW-1:0] m_tdata;
    logic m_tuser;

    logic [15:0] tolerance;
    point_t      pending_points[$];
    int          errors = 0;
    int          n_sent = 0;
    int          n_recv = 0;
    int          n_hits = 0;
    int          idle_pct_s = 0;
    int          idle_pct_m = 0;
    bit          hold_off = 1'b0;
    bit          done = 1'b0;
    int          stall_cnt = 0;
    vec_t        table_rows[$];

    always #5 clk = ~clk;

    segment_intersection_point_top u_top (
        .clk(clk), .rst_n(rst_n), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    function automatic logic signed [63:0] div_trunc(logic signed [127:0] n,
                                                    logic signed [127:0] d);
        logic [127:0] nm;
        logic [127:0] dm;
        logic [127:0] q;
        logic         neg;
        neg = n[127] ^ d[127];
        nm = n[127] ? -n : n;
        dm = d[127] ? -d : d;
        q = nm / dm;
        if (q > (128'd1 << 40))
            q = 128'd1 << 40;
        return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    function automatic logic in_box(logic signed [63:0] v, logic signed [63:0] e0,
                                    logic signed [63:0] e1, logic signed [63:0] tol);
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        lo = (e0 < e1 ? e0 : e1) - tol;
        hi = (e0 < e1 ? e1 : e0) + tol;
        return v >= lo && v <= hi;
    endfunction

    function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic point_t intersect_point(logic signed [31:0] c [8],
                                               logic [15:0] tol);
        point_t r;
        logic signed [127:0] ax, ay, bx, by, cx, cy, dx, dy;
        logic signed [127:0] den, cab, ccd, nx, ny;
        logic signed [63:0] qx, qy, t;
        ax = c[AX]; ay = c[AY]; bx = c[BX]; by = c[BY];
        cx = c[CX]; cy = c[CY]; dx = c[DX]; dy = c[DY];
        if ((ax == cx && ay == cy) || (ax == dx && ay == dy))
        begin
            r.px = c[AX]; r.py = c[AY]; r.hit = 1'b1;
            return r;
        end
        if ((bx == cx && by == cy) || (bx == dx && by == dy))
        begin
            r.px = c[BX]; r.py = c[BY]; r.hit = 1'b1;
            return r;
        end
        den = (ax - bx) * (cy - dy) - (ay - by) * (cx - dx);
        if (den == 0)
        begin
            r.px = 0; r.py = 0; r.hit = 1'b0;
            return r;
        end
        cab = ax * by - ay * bx;
        ccd = cx * dy - cy * dx;
        nx = cab * (cx - dx) - (ax - bx) * ccd;
        ny = cab * (cy - dy) - (ay - by) * ccd;
        qx = div_trunc(nx, den);
        qy = div_trunc(ny, den);
        t = {48'd0, tol};
        r.px = clamp32(qx);
        r.py = clamp32(qy);
        r.hit = in_box(qx, ax[63:0], bx[63:0], t) && in_box(qy, ay[63:0], by[63:0], t)
             && in_box(qx, cx[63:0], dx[63:0], t) && in_box(qy, cy[63:0], dy[63:0], t);
        return r;
    endfunction

    function automatic logic signed [31:0] rand_coord(int mode);
        case (mode)
            0: return $signed($urandom);
            1: return $signed($urandom_range(0, 20) << 16) - (10 << 16);
            2: return $signed($urandom_range(0, 8000)) - 4000;
            default: return $signed($urandom_range(0, 3) == 0 ? 32'h7fffffff :
                                    ($urandom_range(0, 1) ? 32'h80000000 : $urandom));
        endcase
    endfunction

    task automatic send_item(logic signed [31:0] c [8]);
        point_t p;
        int     k;
        while ($urandom_range(1, 100) <= idle_pct_s)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        for (k = 0; k < 8; k++)
            s_tdata[k*CW +: CW] <= c[k];
        s_tvalid <= 1'b1;
        p = intersect_point(c, tolerance);
        pending_points.push_back(p);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic write_tolerance(logic [15:0] v);
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_points.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_wen <= 1'b0;
        tolerance = v;
    endtask

    task automatic add_row(int a0, int a1, int a2, int a3, int a4, int a5, int a6,
                           int a7, logic known, int ex, int ey, logic eh);
        vec_t v;
        v.c[0] = a0; v.c[1] = a1; v.c[2] = a2; v.c[3] = a3;
        v.c[4] = a4; v.c[5] = a5; v.c[6] = a6; v.c[7] = a7;
        v.known = known;
        v.res.px = ex; v.res.py = ey; v.res.hit = eh;
        table_rows.push_back(v);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            point_t e;
            if (pending_points.size() == 0)
            begin
                $error("result transfer with nothing expected: %h %b", m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                e = pending_points.pop_front();
                if (m_tdata[31:0] !== e.px)
                begin
                    $error("hit_x expected %0d actual %0d", e.px, $signed(m_tdata[31:0]));
                    errors++;
                end
                if (m_tdata[63:32] !== e.py)
                begin
                    $error("hit_y expected %0d actual %0d", e.py, $signed(m_tdata[63:32]));
                    errors++;
                end
                if (m_tuser !== e.hit)
                begin
                    $error("intersects expected %0b actual %0b", e.hit, m_tuser);
                    errors++;
                end
                n_recv++;
                n_hits += m_tuser;
            end
        end
    end

    always @(negedge clk)
        m_tready <= !hold_off && ($urandom_range(1, 100) > idle_pct_m);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("timeout: %0d sent, %0d received", n_sent, n_recv);
            $display("tb_segment_intersection_point_top: errors");
            $finish;
        end
    end

    initial
    begin
        logic signed [31:0] c [8];
        int    i;
        int    k;
        int    mode;
        logic [15:0] tols [5];
        tols = '{16'd0, 16'd65535, 16'd1, 16'd3277, 16'd40000};
        tolerance = 16'd3277;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // shared endpoints, parallel, degenerate, extremes
        add_row(1, 2, 3, 4, 1, 2, 9, 9, 1, 1, 2, 1);
        add_row(5, 6, 7, 8, 0, 0, 5, 6, 1, 5, 6, 1);
        add_row(5, 6, 7, 8, 7, 8, 0, 0, 1, 7, 8, 1);
        add_row(5, 6, 7, 8, 1, 1, 7, 8, 1, 7, 8, 1);
        add_row(0, 0, 65536, 0, 0, 65536, 65536, 65536, 1, 0, 0, 0);
        add_row(0, 0, 0, 65536, 65536, 0, 65536, 65536, 1, 0, 0, 0);
        add_row(0, 0, 65536, 65536, 131072, 131072, 196608, 196608, 1, 0, 0, 0);
        add_row(3, 3, 3, 3, 0, 0, 65536, 65536, 1, 0, 0, 0);
        add_row(0, 0, 131072, 131072, 0, 131072, 131072, 0, 0, 0, 0, 0);
        add_row(-65536, 0, 65536, 0, 0, -65536, 0, 65536, 0, 0, 0, 0);
        add_row(0, 0, 65536, 0, 0, 65536, 1, 65536 + 65536, 0, 0, 0, 0);
        add_row(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0);
        add_row(32'h7fffffff, 0, 32'h7ffffffe, 1, 32'h80000000, 0, 32'h80000001, 1,
                0, 0, 0, 0);
        add_row(0, 0, 1, 2, 0, 1, 1, 1, 0, 0, 0, 0);
        add_row(32'hffffffff, 32'hffffffff, 32'h80000000, 32'h7fffffff,
                32'h55555555, 32'haaaaaaaa, 32'h12345678, 32'hedcba987, 0, 0, 0, 0);
        add_row(0, 0, 65536, 0, 68000, -65536, 68000, 65536, 0, 0, 0, 0);

        foreach (table_rows[r])
        begin
            point_t p;
            p = intersect_point(table_rows[r].c, tolerance);
            if (table_rows[r].known && p != table_rows[r].res)
            begin
                $error("table row %0d: predictor disagrees with typed result", r);
                errors++;
            end
            send_item(table_rows[r].c);
        end

        for (i = 0; i < 1500; i++)
        begin
            if (i % 300 == 0)
            begin
                write_tolerance(tols[i / 300]);
                case ((i / 300) % 4)
                    0: begin idle_pct_s = 0;  idle_pct_m = 0;  end
                    1: begin idle_pct_s = 53; idle_pct_m = 0;  end
                    2: begin idle_pct_s = 0;  idle_pct_m = 53; end
                    default: begin idle_pct_s = 11; idle_pct_m = 11; end
                endcase
                if (i == 600)
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (200) @(negedge clk);
                            hold_off = 1'b0;
                        end
                    join_none
            end
            mode = $urandom_range(0, 3);
            for (k = 0; k < 8; k++)
                c[k] = rand_coord(mode);
            case ($urandom_range(0, 9))
                0: begin c[CX] = c[AX]; c[CY] = c[AY]; end
                1: begin c[DX] = c[BX]; c[DY] = c[BY]; end
                2: begin c[DX] = c[CX] + (c[BX] - c[AX]); c[DY] = c[CY] + (c[BY] - c[AY]); end
                3: begin c[BX] = c[AX]; c[BY] = c[AY]; end
                default: ;
            endcase
            send_item(c);
        end
        s_tvalid <= 1'b0;
        idle_pct_m = 0;
        while (pending_points.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        $display("covered %0d segment pairs, %0d results, %0d hits, 5 tolerance settings",
                 n_sent, n_recv, n_hits);
        if (errors == 0)
            $display("tb_segment_intersection_point_top: clean");
        else
            $display("tb_segment_intersection_point_top: errors");
        $finish;
    end

endmodule
